// ----- rtl/core/dbl_pkg.sv -----
// Shared types and constants for the depth buffer linearizer core.
// Used by dbl_cfg, dbl_front, dbl_div_cell and depth_buffer_linearizer_core.
package dbl_pkg;

  localparam int unsigned MAX_DIM   = 4096;
  localparam int unsigned DIM_W     = 13;
  localparam int unsigned ROW_W     = 12;
  localparam int unsigned IDX_W     = 24;
  localparam int unsigned Z_W       = 25;
  localparam int unsigned PLANE_W   = 32;
  localparam int unsigned QUO_W     = 32;
  localparam int unsigned DVS_W     = 58;
  localparam int unsigned FEED_W    = 8;
  localparam int unsigned NUM_CELLS = QUO_W;
  localparam int unsigned ADDR_W    = 5;

  typedef enum logic [2:0] {
    REG_NEAR   = 3'd0,
    REG_FAR    = 3'd1,
    REG_MODE   = 3'd2,
    REG_WIDTH  = 3'd3,
    REG_HEIGHT = 3'd4
  } reg_idx_t;

  localparam logic [PLANE_W-1:0] NEAR_RST   = 32'd655;
  localparam logic [PLANE_W-1:0] FAR_RST    = 32'd6553600;
  localparam logic               MODE_RST   = 1'b0;
  localparam logic [DIM_W-1:0]   WIDTH_RST  = 13'd640;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 13'd480;

  typedef struct packed {
    logic [PLANE_W-1:0] near_clip;
    logic [PLANE_W-1:0] far_clip;
    logic               depth_mode;
    logic [DIM_W-1:0]   frame_width;
    logic [DIM_W-1:0]   frame_height;
  } cfg_t;

  // Token travelling along the divider chain.
  typedef struct packed {
    logic               valid;
    logic               sat;
    logic [DVS_W-1:0]   rem;
    logic [DVS_W-1:0]   dvs;
    logic [FEED_W-1:0]  feed;
    logic [QUO_W-1:0]   quo;
    logic [ROW_W-1:0]   drow;
    logic [IDX_W-1:0]   idx;
  } cell_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] lim;
    lim = DIM_W'(MAX_DIM);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ----- rtl/core/dbl_cfg.sv -----
// APB-style configuration register file for the depth buffer linearizer.
// Depends on dbl_pkg for register indexes, reset values and cfg_t.
module dbl_cfg import dbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_NEAR:   cfg_nxt.near_clip    = cfg_pwdata;
        REG_FAR:    cfg_nxt.far_clip     = cfg_pwdata;
        REG_MODE:   cfg_nxt.depth_mode   = cfg_pwdata[0];
        REG_WIDTH:  cfg_nxt.frame_width  = cfg_pwdata[DIM_W-1:0];
        REG_HEIGHT: cfg_nxt.frame_height = cfg_pwdata[DIM_W-1:0];
        default:    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NEAR:   cfg_prdata = cfg_r.near_clip;
      REG_FAR:    cfg_prdata = cfg_r.far_clip;
      REG_MODE:   cfg_prdata = {31'd0, cfg_r.depth_mode};
      REG_WIDTH:  cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.frame_width};
      REG_HEIGHT: cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.frame_height};
      default:    cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.near_clip    <= NEAR_RST;
      cfg_r.far_clip     <= FAR_RST;
      cfg_r.depth_mode   <= MODE_RST;
      cfg_r.frame_width  <= WIDTH_RST;
      cfg_r.frame_height <= HEIGHT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- rtl/core/dbl_front.sv -----
// Front end of the linearizer: products, divisor, range check and row mapping.
// Depends on dbl_pkg; feeds the first dbl_div_cell with a cell_t token.
module dbl_front import dbl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_valid,
  input  logic [Z_W-1:0]   in_depth_code,
  input  logic [ROW_W-1:0] in_source_row,
  input  logic [ROW_W-1:0] in_column,
  input  cfg_t             cfg,
  output cell_t            head
);

  // Stage 1: the two multiplications and the mirrored row.
  logic signed [PLANE_W:0]     range_s;
  logic signed [Z_W:0]         z_s;
  logic signed [Z_W+PLANE_W+1:0] zr;
  logic [DIM_W-1:0]            w_cl;
  logic [DIM_W-1:0]            h_cl;
  logic [DIM_W-1:0]            drow_full;

  logic                        s1_valid_r;
  logic [2*PLANE_W-1:0]        s1_prod_r;
  logic signed [Z_W+PLANE_W+1:0] s1_zr_r;
  logic [PLANE_W-1:0]          s1_base_r;
  logic                        s1_mode_r;
  logic [ROW_W-1:0]            s1_drow_r;
  logic [DIM_W-1:0]            s1_w_r;
  logic [ROW_W-1:0]            s1_col_r;

  assign range_s   = $signed({1'b0, cfg.far_clip}) - $signed({1'b0, cfg.near_clip});
  assign z_s       = $signed({1'b0, in_depth_code});
  assign zr        = z_s * range_s;
  assign w_cl      = clamp_dim(cfg.frame_width);
  assign h_cl      = clamp_dim(cfg.frame_height);
  assign drow_full = h_cl - DIM_W'(1) - {1'b0, in_source_row};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_prod_r <= cfg.near_clip * cfg.far_clip;
      s1_zr_r   <= zr;
      s1_base_r <= cfg.depth_mode ? cfg.far_clip : cfg.near_clip;
      s1_mode_r <= cfg.depth_mode;
      s1_drow_r <= drow_full[ROW_W-1:0];
      s1_w_r    <= w_cl;
      s1_col_r  <= in_column;
    end
  end

  // Stage 2: signed divisor and destination index.
  localparam int unsigned DIV_W = DVS_W + 2;

  logic signed [DIV_W-1:0]     base_s;
  logic signed [DIV_W-1:0]     zr_ext;
  logic signed [DIV_W-1:0]     div_s;
  logic [ROW_W+DIM_W-1:0]      idx_full;

  logic                        s2_valid_r;
  logic [2*PLANE_W-1:0]        s2_prod_r;
  logic [DVS_W-1:0]            s2_dvs_r;
  logic                        s2_pos_r;
  logic [ROW_W-1:0]            s2_drow_r;
  logic [IDX_W-1:0]            s2_idx_r;

  assign base_s   = $signed({{(DIV_W-PLANE_W-24){1'b0}}, s1_base_r, 24'd0});
  assign zr_ext   = DIV_W'(s1_zr_r);
  assign div_s    = s1_mode_r ? (base_s - zr_ext) : (base_s + zr_ext);
  assign idx_full = s1_drow_r * s1_w_r + (ROW_W+DIM_W)'(s1_col_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_prod_r <= s1_prod_r;
      s2_dvs_r  <= div_s[DVS_W-1:0];
      s2_pos_r  <= !div_s[DIV_W-1] && (div_s != '0);
      s2_drow_r <= s1_drow_r;
      s2_idx_r  <= idx_full[IDX_W-1:0];
    end
  end

  // Stage 3: the quotient fits 32 bits exactly when prod < divisor * 2^8.
  logic  ovf;
  cell_t head_r;

  assign ovf  = ({2'b00, s2_prod_r} >= {s2_dvs_r, 8'd0});
  assign head = head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.valid <= 1'b0;
    end else if (adv) begin
      head_r.valid <= s2_valid_r;
    end
    if (adv) begin
      head_r.sat  <= !s2_pos_r || ovf;
      head_r.rem  <= DVS_W'(s2_prod_r[2*PLANE_W-1:FEED_W]);
      head_r.dvs  <= s2_dvs_r;
      head_r.feed <= s2_prod_r[FEED_W-1:0];
      head_r.quo  <= '0;
      head_r.drow <= s2_drow_r;
      head_r.idx  <= s2_idx_r;
    end
  end

endmodule

// ----- rtl/core/dbl_div_cell.sv -----
// One restoring-division cell: produces one quotient bit per token.
// Depends on dbl_pkg for cell_t.
module dbl_div_cell import dbl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  adv,
  input  cell_t din,
  output cell_t dout
);

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;
  cell_t            dout_r;

  // For a token that is not saturated, the remainder stays below the divisor, so it fits DVS_W bits.
  assign trial = {din.rem, din.feed[FEED_W-1]};
  assign diff  = trial - {1'b0, din.dvs};
  assign take  = (trial >= {1'b0, din.dvs});
  assign dout  = dout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dout_r.valid <= 1'b0;
    end else if (adv) begin
      dout_r.valid <= din.valid;
    end
    if (adv) begin
      dout_r.sat  <= din.sat;
      dout_r.rem  <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dout_r.dvs  <= din.dvs;
      dout_r.feed <= {din.feed[FEED_W-2:0], 1'b0};
      dout_r.quo  <= {din.quo[QUO_W-2:0], take};
      dout_r.drow <= din.drow;
      dout_r.idx  <= din.idx;
    end
  end

endmodule

// ----- rtl/core/depth_buffer_linearizer_core.sv -----
// Top level of the depth buffer linearizer: register file, front end and divider chain.
// Depends on dbl_pkg, dbl_cfg, dbl_front and dbl_div_cell.
//
//   Port group  Direction  Handshake           Contents
//   in_*        input      in_valid/in_stall   depth_code, source_row, column
//   out_*       output     out_valid/out_stall distance, dest_row, dest_index, saturated
//   cfg_*       input      APB write/read      near, far, mode, width, height
//
// One sample is taken every clock cycle unless the pipeline is stalled; each result passes
// through three front-end stages followed by a row of 32 division cells, one quotient
// bit per cell, 35 registers.
// Reset loads the register defaults and empties the pipeline; no clearing pass.
// A stalled result freezes the whole pipeline, and the input is stalled in that
// same cycle; while the output is taken, a new transfer is accepted each cycle.
module depth_buffer_linearizer_core import dbl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [Z_W-1:0]    in_depth_code,
  input  logic [ROW_W-1:0]  in_source_row,
  input  logic [ROW_W-1:0]  in_column,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [QUO_W-1:0]  out_distance,
  output logic [ROW_W-1:0]  out_dest_row,
  output logic [IDX_W-1:0]  out_dest_index,
  output logic              out_saturated,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  cfg_t  cfg;
  cell_t chain [NUM_CELLS+1];
  cell_t tail;
  logic  adv;

  // The last cell's register doubles as the output register. The pipeline
  // moves whenever that register is empty or its contents are being taken.
  assign tail     = chain[NUM_CELLS];
  assign adv      = !(tail.valid && out_stall);
  assign in_stall = !adv;

  dbl_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  dbl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .adv           (adv),
    .in_valid      (in_valid),
    .in_depth_code (in_depth_code),
    .in_source_row (in_source_row),
    .in_column     (in_column),
    .cfg           (cfg),
    .head          (chain[0])
  );

  // Each cell shifts in one dividend bit and settles one quotient bit.
  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    dbl_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .adv   (adv),
      .din   (chain[g]),
      .dout  (chain[g+1])
    );
  end

  // A nonpositive divisor or an oversized quotient forces full scale.
  assign out_valid      = tail.valid;
  assign out_distance   = tail.sat ? {QUO_W{1'b1}} : tail.quo;
  assign out_dest_row   = tail.drow;
  assign out_dest_index = tail.idx;
  assign out_saturated  = tail.sat;

endmodule
